[src/icu_pkg.sv]
// Shared types and constants of the ichimoku cloud indicator unit.
// Used by the interfaces, the controller and the datapath; no dependencies.
package icu_pkg;

   // Configuration register layout
   localparam int PERIOD_W     = 7;
   localparam int SHIFT_W      = 6;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 7;
   localparam int NUM_WINDOWS  = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_CONVERSION_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_PERIOD       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPAN_B_PERIOD     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LEAD_SHIFT        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LAG_SHIFT         = 3'd4;

   localparam logic [PERIOD_W-1:0] CONVERSION_PERIOD_RST = 7'd9;
   localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST       = 7'd26;
   localparam logic [PERIOD_W-1:0] SPAN_B_PERIOD_RST     = 7'd52;
   localparam logic [SHIFT_W-1:0]  LEAD_SHIFT_RST        = 6'd26;
   localparam logic [SHIFT_W-1:0]  LAG_SHIFT_RST         = 6'd26;

   // Window slots in the datapath
   localparam int WIN_CONV   = 0;
   localparam int WIN_BASE   = 1;
   localparam int WIN_SPAN_B = 2;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // take the bar, write history
      logic setup;     // clamp periods, size the scan
      logic scan_run;  // walk the history
      logic sum;       // form high+low per window
      logic dwrite;    // write delay lines
      logic dread;     // read delayed values
      logic load_out;  // fill the response register
   } icu_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
   } icu_status_type;

endpackage

[src/icu_if.sv]
// Request, response and register-write channels of the indicator unit.
// Depends on icu_pkg for the register port widths.

interface icu_req_if #(parameter int PRICE_BITS = 32) ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] bar_high;
   logic [PRICE_BITS-1:0] bar_low;
   logic [PRICE_BITS-1:0] bar_close;

   modport source (output valid, bar_high, bar_low, bar_close, input ready);
   modport sink   (input valid, bar_high, bar_low, bar_close, output ready);
endinterface

interface icu_rsp_if #(parameter int PRICE_BITS = 32) ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS:0]   conversion_sum;
   logic                  conversion_valid;
   logic [PRICE_BITS:0]   base_sum;
   logic                  base_valid;
   logic [PRICE_BITS+1:0] span_a_quad;
   logic                  span_a_valid;
   logic [PRICE_BITS:0]   span_b_sum;
   logic                  span_b_valid;
   logic [PRICE_BITS-1:0] lagging_close;
   logic                  lagging_valid;

   modport source (output valid, conversion_sum, conversion_valid, base_sum, base_valid,
                   span_a_quad, span_a_valid, span_b_sum, span_b_valid, lagging_close,
                   lagging_valid, input ready);
   modport sink   (input valid, conversion_sum, conversion_valid, base_sum, base_valid,
                   span_a_quad, span_a_valid, span_b_sum, span_b_valid, lagging_close,
                   lagging_valid, output ready);
endinterface

interface icu_csr_if ();
   logic                               valid;
   logic                               ready;
   logic [icu_pkg::CSR_INDEX_W-1:0]    reg_index;
   logic [icu_pkg::CSR_DATA_W-1:0]     wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[src/ichimoku_cloud_indicator_unit.sv]
// Top level of the ichimoku cloud indicator unit.
// Depends on icu_pkg, the channel interfaces, icu_ctrl and icu_dp.
//
//  channel | modport | moves                                | handshake
//  --------+---------+--------------------------------------+--------------
//  req_bus | sink    | one price bar (high, low, close)     | valid/ready
//  rsp_bus | source  | lines, spans, lagging close + flags  | valid/ready
//  csr_bus | sink    | register index and write data        | valid/ready
//
// Sequence: a request is taken, then setup, history scan, sums, delay line
//   write and read and response load follow in turn; the next request is
//   taken once the response is loaded. The scan reads N history entries, N
//   being the longest of the three clamped windows over the bars seen so far
//   (up to 64 at WINDOW_DEPTH 64), one entry a cycle on the single read port.
// Registers are always writable (csr_bus.ready tied high); writes beyond
//   the last register index are dropped.
// Reset clears counters, pointers, delay valid bits and the handshake.
// A stalled response holds in its register; the next request is taken
//   meanwhile and its result waits until that register drains.
module ichimoku_cloud_indicator_unit #(
   parameter int WINDOW_DEPTH = 64,
   parameter int DELAY_DEPTH  = 64,
   parameter int PRICE_BITS   = 32
) (
   input  logic      clock,
   input  logic      reset,
   icu_req_if.sink   req_bus,
   icu_rsp_if.source rsp_bus,
   icu_csr_if.sink   csr_bus
);

   icu_pkg::icu_cmd_type    cmd;
   icu_pkg::icu_status_type status;

   // register port never stalls
   assign csr_bus.ready = 1'b1;

   // sequencer: one request in flight through the datapath
   icu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // history scan, delay lines and response register
   icu_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .DELAY_DEPTH  (DELAY_DEPTH),
      .PRICE_BITS   (PRICE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .bar_high         (req_bus.bar_high),
      .bar_low          (req_bus.bar_low),
      .bar_close        (req_bus.bar_close),
      .csr_write        (csr_bus.valid),
      .csr_index        (csr_bus.reg_index),
      .csr_data         (csr_bus.wr_data),
      .conversion_sum   (rsp_bus.conversion_sum),
      .conversion_valid (rsp_bus.conversion_valid),
      .base_sum         (rsp_bus.base_sum),
      .base_valid       (rsp_bus.base_valid),
      .span_a_quad      (rsp_bus.span_a_quad),
      .span_a_valid     (rsp_bus.span_a_valid),
      .span_b_sum       (rsp_bus.span_b_sum),
      .span_b_valid     (rsp_bus.span_b_valid),
      .lagging_close    (rsp_bus.lagging_close),
      .lagging_valid    (rsp_bus.lagging_valid)
   );

endmodule

[src/icu_ctrl.sv]
// Sequencer of the indicator unit: steps one request through setup, scan,
// delay lines and response. Depends on icu_pkg.
module icu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output icu_pkg::icu_cmd_type    cmd,
   input  icu_pkg::icu_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_SCAN, ST_SUM, ST_DWRITE, ST_DREAD, ST_DOUT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.accept   = req_valid && req_ready_ff;
         ST_SETUP:  cmd.setup    = 1'b1;
         ST_SCAN:   cmd.scan_run = 1'b1;
         ST_SUM:    cmd.sum      = 1'b1;
         ST_DWRITE: cmd.dwrite   = 1'b1;
         ST_DREAD:  cmd.dread    = 1'b1;
         ST_DOUT:   cmd.load_out = out_free;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response register: loaded at the end of a request, cleared once taken
         if (state_ff == ST_DOUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_SETUP;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_SETUP:  state_ff <= ST_SCAN;
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM:    state_ff <= ST_DWRITE;
            ST_DWRITE: state_ff <= ST_DREAD;
            ST_DREAD:  state_ff <= ST_DOUT;
            ST_DOUT: begin
               // wait for the response register to drain
               if (out_free) begin
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

[src/icu_dp.sv]
// Datapath of the indicator unit: register file, price history memories,
// window scan, delay line memories and response register. Depends on icu_pkg.
module icu_dp #(
   parameter int WINDOW_DEPTH = 64,
   parameter int DELAY_DEPTH  = 64,
   parameter int PRICE_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  icu_pkg::icu_cmd_type              cmd,
   output icu_pkg::icu_status_type           status,
   input  logic [PRICE_BITS-1:0]             bar_high,
   input  logic [PRICE_BITS-1:0]             bar_low,
   input  logic [PRICE_BITS-1:0]             bar_close,
   input  logic                              csr_write,
   input  logic [icu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [icu_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [PRICE_BITS:0]               conversion_sum,
   output logic                              conversion_valid,
   output logic [PRICE_BITS:0]               base_sum,
   output logic                              base_valid,
   output logic [PRICE_BITS+1:0]             span_a_quad,
   output logic                              span_a_valid,
   output logic [PRICE_BITS:0]               span_b_sum,
   output logic                              span_b_valid,
   output logic [PRICE_BITS-1:0]             lagging_close,
   output logic                              lagging_valid
);

   localparam int NW     = icu_pkg::NUM_WINDOWS;
   localparam int WPW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int DPW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int BW     = $clog2(WINDOW_DEPTH + 1);
   localparam int PW     = (BW > icu_pkg::PERIOD_W) ? BW : icu_pkg::PERIOD_W;
   localparam int SW     = (DPW + 1 > icu_pkg::SHIFT_W) ? DPW + 1 : icu_pkg::SHIFT_W;
   localparam int SUM_W  = PRICE_BITS + 1;
   localparam int QUAD_W = PRICE_BITS + 2;
   localparam int AB_W   = QUAD_W + 1 + SUM_W + 1;

   // ---------------- register file ----------------
   logic [icu_pkg::PERIOD_W-1:0] period_ff [NW];
   logic [icu_pkg::SHIFT_W-1:0]  lead_shift_ff;
   logic [icu_pkg::SHIFT_W-1:0]  lag_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff[icu_pkg::WIN_CONV]   <= icu_pkg::CONVERSION_PERIOD_RST;
         period_ff[icu_pkg::WIN_BASE]   <= icu_pkg::BASE_PERIOD_RST;
         period_ff[icu_pkg::WIN_SPAN_B] <= icu_pkg::SPAN_B_PERIOD_RST;
         lead_shift_ff                  <= icu_pkg::LEAD_SHIFT_RST;
         lag_shift_ff                   <= icu_pkg::LAG_SHIFT_RST;
      end else if (csr_write) begin
         case (csr_index)
            icu_pkg::REG_CONVERSION_PERIOD: period_ff[icu_pkg::WIN_CONV]   <= csr_data;
            icu_pkg::REG_BASE_PERIOD:       period_ff[icu_pkg::WIN_BASE]   <= csr_data;
            icu_pkg::REG_SPAN_B_PERIOD:     period_ff[icu_pkg::WIN_SPAN_B] <= csr_data;
            icu_pkg::REG_LEAD_SHIFT: lead_shift_ff <= csr_data[icu_pkg::SHIFT_W-1:0];
            icu_pkg::REG_LAG_SHIFT:  lag_shift_ff  <= csr_data[icu_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- history and bar counters ----------------
   logic [WPW-1:0]        hptr_ff;
   logic [BW-1:0]         bars_ff;
   logic [DPW-1:0]        dptr_ff;
   logic [PRICE_BITS-1:0] close_ff;
   logic [PRICE_BITS-1:0] high_mem [WINDOW_DEPTH];
   logic [PRICE_BITS-1:0] low_mem  [WINDOW_DEPTH];
   logic [PRICE_BITS-1:0] hi_rd_ff;
   logic [PRICE_BITS-1:0] lo_rd_ff;

   // scan control
   logic [WPW-1:0] scan_addr_ff;
   logic [BW-1:0]  cnt_ff;
   logic [BW-1:0]  rd_k_ff;
   logic           rd_valid_ff;
   logic [BW-1:0]  nmax_ff;
   logic           scan_issue;

   assign scan_issue = cmd.scan_run && (cnt_ff < nmax_ff);
   assign status.scan_done = (cnt_ff == nmax_ff) && !rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hptr_ff     <= '0;
         bars_ff     <= '0;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            hptr_ff <= (hptr_ff == WPW'(WINDOW_DEPTH - 1)) ? '0 : hptr_ff + 1'b1;
            if (bars_ff < BW'(WINDOW_DEPTH)) begin
               bars_ff <= bars_ff + 1'b1;
            end
         end
         if (cmd.setup) begin
            cnt_ff      <= '0;
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            rd_valid_ff <= scan_issue;
            if (scan_issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         high_mem[hptr_ff] <= bar_high;
         low_mem[hptr_ff]  <= bar_low;
         close_ff          <= bar_close;
         scan_addr_ff      <= hptr_ff;  // newest bar, scan walks backward
      end else if (scan_issue) begin
         scan_addr_ff <= (scan_addr_ff == '0) ? WPW'(WINDOW_DEPTH - 1) : scan_addr_ff - 1'b1;
      end
      if (scan_issue) begin
         hi_rd_ff <= high_mem[scan_addr_ff];
         lo_rd_ff <= low_mem[scan_addr_ff];
         rd_k_ff  <= cnt_ff;
      end
   end

   // ---------------- window setup ----------------
   logic [PW-1:0] pext    [NW];
   logic [BW-1:0] pclamp  [NW];
   logic [BW-1:0] n_in    [NW];
   logic [NW-1:0] full_in;
   logic [BW-1:0] m01;
   logic [BW-1:0] nmax_in;
   logic [BW-1:0] n_ff    [NW];
   logic [NW-1:0] full_ff;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         pext[i] = PW'(period_ff[i]);
         if (pext[i] == '0) begin
            pclamp[i] = BW'(1);
         end else if (pext[i] > PW'(WINDOW_DEPTH)) begin
            pclamp[i] = BW'(WINDOW_DEPTH);
         end else begin
            pclamp[i] = pext[i][BW-1:0];
         end
         n_in[i]    = (pclamp[i] < bars_ff) ? pclamp[i] : bars_ff;
         full_in[i] = (bars_ff >= pclamp[i]);
      end
      m01     = (n_in[0] > n_in[1]) ? n_in[0] : n_in[1];
      nmax_in = (m01 > n_in[2]) ? m01 : n_in[2];
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         for (int i = 0; i < NW; i++) begin
            n_ff[i] <= n_in[i];
         end
         full_ff <= full_in;
         nmax_ff <= nmax_in;
      end
   end

   // ---------------- extreme accumulators ----------------
   logic [PRICE_BITS-1:0] hi_ff  [NW];
   logic [PRICE_BITS-1:0] lo_ff  [NW];
   logic [SUM_W-1:0]      sum_ff [NW];

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         for (int i = 0; i < NW; i++) begin
            if (rd_k_ff < n_ff[i]) begin
               if (rd_k_ff == '0) begin
                  hi_ff[i] <= hi_rd_ff;
                  lo_ff[i] <= lo_rd_ff;
               end else begin
                  if (hi_rd_ff > hi_ff[i]) hi_ff[i] <= hi_rd_ff;
                  if (lo_rd_ff < lo_ff[i]) lo_ff[i] <= lo_rd_ff;
               end
            end
         end
      end
      if (cmd.sum) begin
         for (int i = 0; i < NW; i++) begin
            sum_ff[i] <= SUM_W'(hi_ff[i]) + SUM_W'(lo_ff[i]);
         end
      end
   end

   // ---------------- delay lines ----------------
   logic [AB_W-1:0]        ab_mem    [DELAY_DEPTH];
   logic [PRICE_BITS-1:0]  close_mem [DELAY_DEPTH];
   logic [DELAY_DEPTH-1:0] written_ff;
   logic [QUAD_W-1:0]      quad;
   logic [SW-1:0]          lead_ext, lag_ext;
   logic [DPW-1:0]         lead_c, lag_c;
   logic [DPW:0]           a_idx_w, c_idx_w;
   logic [DPW-1:0]         a_idx, c_idx;
   logic [AB_W-1:0]        ab_rd_ff;
   logic [PRICE_BITS-1:0]  cl_rd_ff;
   logic                   a_wr_ff, c_wr_ff;

   assign quad = QUAD_W'(sum_ff[icu_pkg::WIN_CONV]) + QUAD_W'(sum_ff[icu_pkg::WIN_BASE]);

   always_comb begin
      lead_ext = SW'(lead_shift_ff);
      lag_ext  = SW'(lag_shift_ff);
      lead_c = (lead_ext > SW'(DELAY_DEPTH - 1)) ? DPW'(DELAY_DEPTH - 1) : lead_ext[DPW-1:0];
      lag_c  = (lag_ext > SW'(DELAY_DEPTH - 1)) ? DPW'(DELAY_DEPTH - 1) : lag_ext[DPW-1:0];
      a_idx_w = (dptr_ff >= lead_c) ? (DPW + 1)'(dptr_ff - lead_c)
                                    : (DPW + 1)'(dptr_ff) + (DPW + 1)'(DELAY_DEPTH)
                                      - (DPW + 1)'(lead_c);
      c_idx_w = (dptr_ff >= lag_c) ? (DPW + 1)'(dptr_ff - lag_c)
                                   : (DPW + 1)'(dptr_ff) + (DPW + 1)'(DELAY_DEPTH)
                                     - (DPW + 1)'(lag_c);
      a_idx = a_idx_w[DPW-1:0];
      c_idx = c_idx_w[DPW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dptr_ff    <= '0;
         written_ff <= '0;
      end else begin
         if (cmd.dwrite) begin
            written_ff[dptr_ff] <= 1'b1;
         end
         if (cmd.dread) begin
            dptr_ff <= (dptr_ff == DPW'(DELAY_DEPTH - 1)) ? '0 : dptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dwrite) begin
         ab_mem[dptr_ff] <= {quad, full_ff[icu_pkg::WIN_CONV] & full_ff[icu_pkg::WIN_BASE],
                             sum_ff[icu_pkg::WIN_SPAN_B], full_ff[icu_pkg::WIN_SPAN_B]};
         close_mem[dptr_ff] <= close_ff;
      end
      // read after write: a zero shift returns the entry just written
      if (cmd.dread) begin
         ab_rd_ff <= ab_mem[a_idx];
         cl_rd_ff <= close_mem[c_idx];
         a_wr_ff  <= written_ff[a_idx];
         c_wr_ff  <= written_ff[c_idx];
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         conversion_sum   <= sum_ff[icu_pkg::WIN_CONV];
         conversion_valid <= full_ff[icu_pkg::WIN_CONV];
         base_sum         <= sum_ff[icu_pkg::WIN_BASE];
         base_valid       <= full_ff[icu_pkg::WIN_BASE];
         span_a_quad      <= a_wr_ff ? ab_rd_ff[AB_W-1 -: QUAD_W] : '0;
         span_a_valid     <= a_wr_ff & ab_rd_ff[SUM_W + 1];
         span_b_sum       <= a_wr_ff ? ab_rd_ff[SUM_W:1] : '0;
         span_b_valid     <= a_wr_ff & ab_rd_ff[0];
         lagging_close    <= c_wr_ff ? cl_rd_ff : '0;
         lagging_valid    <= c_wr_ff;
      end
   end

endmodule

[src/icu_checker.sv]
// Port-level checks of the indicator unit, bound to the top level.
// Depends only on the top level's channel signals.
module icu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic [1:0] pend_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pend_ff <= pend_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pend_ff <= pend_ff - 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request taken while another is in work");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many requests pending");

endmodule

bind ichimoku_cloud_indicator_unit icu_checker u_icu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
